[rtl/fpba_pkg.sv]
package fpba_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int POLICY_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 1'b1;

  // operations
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // fit rules; the unused code behaves as first fit
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } fpba_state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic scan;
    logic commit;
  } fpba_cmd_t;

  typedef struct packed {
    logic scan_done;
  } fpba_sts_t;

endpackage

[rtl/fpba_ram.sv]
module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/fpba_ctrl.sv]
module fpba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_operation,
  input  fpba_pkg::fpba_sts_t sts,
  output fpba_pkg::fpba_cmd_t cmd,
  output logic               busy
);

  fpba_pkg::fpba_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpba_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fpba_pkg::S_IDLE: begin
        if (start && in_operation == fpba_pkg::OP_ALLOC) begin
          state_nxt = fpba_pkg::S_SCAN;
        end
      end
      fpba_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = fpba_pkg::S_COMMIT;
        end
      end
      fpba_pkg::S_COMMIT: state_nxt = fpba_pkg::S_IDLE;
      default:            state_nxt = fpba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      fpba_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start && in_operation == fpba_pkg::OP_LOAD;
        cmd.init = start && in_operation == fpba_pkg::OP_ALLOC;
      end
      fpba_pkg::S_SCAN:   cmd.scan   = 1'b1;
      fpba_pkg::S_COMMIT: cmd.commit = 1'b1;
      default:            busy       = 1'b1;
    endcase
  end

endmodule

[rtl/fpba_dp.sv]
module fpba_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fpba_pkg::fpba_cmd_t                   cmd,
  output fpba_pkg::fpba_sts_t                   sts,
  input  logic [fpba_pkg::IDX_W-1:0]            in_load_index,
  input  logic [fpba_pkg::SIZE_BITS-1:0]        in_size_value,
  input  logic                                  cfg_we,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fpba_pkg::CFG_W-1:0]            cfg_wdata,
  output logic                                  out_strobe,
  output logic                                  out_granted,
  output logic [fpba_pkg::IDX_W-1:0]            out_chosen_block,
  output logic [fpba_pkg::SIZE_BITS-1:0]        out_space_left
);

  // configuration
  logic [fpba_pkg::POLICY_W-1:0] policy_r;
  logic [fpba_pkg::COUNT_W-1:0]  count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= fpba_pkg::POL_FIRST;
      count_r  <= fpba_pkg::COUNT_W'(fpba_pkg::MAX_BLOCKS);
    end else if (cfg_we) begin
      case (cfg_index)
        fpba_pkg::REG_POLICY: policy_r <= cfg_wdata[fpba_pkg::POLICY_W-1:0];
        fpba_pkg::REG_COUNT:  count_r  <= cfg_wdata[fpba_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [fpba_pkg::CNT_W-1:0] limit;
  logic                       mode_best, mode_worst, mode_first;

  assign limit = (32'(count_r) > fpba_pkg::MAX_BLOCKS) ?
                 fpba_pkg::CNT_W'(fpba_pkg::MAX_BLOCKS) : fpba_pkg::CNT_W'(count_r);
  assign mode_best  = policy_r == fpba_pkg::POL_BEST;
  assign mode_worst = policy_r == fpba_pkg::POL_WORST;
  assign mode_first = !mode_best && !mode_worst;

  // scan state: issue counter runs one entry ahead of the compare stage
  logic [fpba_pkg::CNT_W-1:0]     iss_r, iss_nxt;
  logic                           cmp_vld_r, cmp_vld_nxt;
  logic [fpba_pkg::IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [fpba_pkg::SIZE_BITS-1:0] req_r, req_nxt;
  logic                           pick_vld_r, pick_vld_nxt;
  logic [fpba_pkg::IDX_W-1:0]     pick_idx_r, pick_idx_nxt;
  logic [fpba_pkg::SIZE_BITS-1:0] pick_size_r, pick_size_nxt;

  logic [fpba_pkg::SIZE_BITS-1:0] rd_data;
  logic                           fits, better, take;

  assign fits   = rd_data >= req_r;
  assign better = (mode_best && rd_data < pick_size_r) ||
                  (mode_worst && rd_data > pick_size_r);
  assign take   = cmd.scan && cmp_vld_r && fits && (!pick_vld_r || better);

  always_comb begin
    iss_nxt       = iss_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    req_nxt       = req_r;
    pick_vld_nxt  = pick_vld_r;
    pick_idx_nxt  = pick_idx_r;
    pick_size_nxt = pick_size_r;
    if (cmd.init) begin
      iss_nxt      = '0;
      req_nxt      = in_size_value;
      pick_vld_nxt = 1'b0;
    end else if (cmd.scan) begin
      if (iss_r < limit) begin
        iss_nxt     = iss_r + 1'b1;
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = iss_r[fpba_pkg::IDX_W-1:0];
      end
      if (take) begin
        pick_vld_nxt  = 1'b1;
        pick_idx_nxt  = cmp_idx_r;
        pick_size_nxt = rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r      <= '0;
      cmp_vld_r  <= 1'b0;
      pick_vld_r <= 1'b0;
    end else begin
      iss_r      <= iss_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      pick_vld_r <= pick_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r   <= cmp_idx_nxt;
    req_r       <= req_nxt;
    pick_idx_r  <= pick_idx_nxt;
    pick_size_r <= pick_size_nxt;
  end

  // first fit stops as soon as a block is held
  assign sts.scan_done = (iss_r == limit && !cmp_vld_r) || (mode_first && pick_vld_r);

  // free size table
  logic [fpba_pkg::SIZE_BITS-1:0] left;
  logic                           ram_we;
  logic [fpba_pkg::IDX_W-1:0]     ram_waddr;
  logic [fpba_pkg::SIZE_BITS-1:0] ram_wdata;

  assign left      = pick_size_r - req_r;
  assign ram_we    = (cmd.load && 32'(in_load_index) < fpba_pkg::MAX_BLOCKS) ||
                     (cmd.commit && pick_vld_r);
  assign ram_waddr = cmd.commit ? pick_idx_r : in_load_index;
  assign ram_wdata = cmd.commit ? left : in_size_value;

  fpba_ram #(
    .WIDTH(fpba_pkg::SIZE_BITS),
    .DEPTH(fpba_pkg::MAX_BLOCKS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(iss_r[fpba_pkg::IDX_W-1:0]),
    .rdata(rd_data)
  );

  // result word register
  logic                           strobe_r;
  logic                           granted_r;
  logic [fpba_pkg::IDX_W-1:0]     chosen_r;
  logic [fpba_pkg::SIZE_BITS-1:0] space_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      granted_r <= pick_vld_r;
      chosen_r  <= pick_vld_r ? pick_idx_r : '0;
      space_r   <= pick_vld_r ? left : '0;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_granted      = granted_r;
  assign out_chosen_block = chosen_r;
  assign out_space_left   = space_r;

endmodule

[rtl/fit_policy_block_allocator_core.sv]
// Load word: no result; busy stays low, so loads may follow back to back.
// Allocate word: busy while the table is scanned (count capped at 16) and the choice is written
// back; first fit ends the scan at its first hit. The result word is registered and appears as busy drops.
// The free size table is scanned serially, one entry per cycle through its read port.
// Synchronous active-low reset clears the controller, policy (first fit) and count (16);
// the table holds no defined value until loaded. Results cannot be stalled.
module fit_policy_block_allocator_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_operation,
  input  logic [fpba_pkg::IDX_W-1:0]            in_load_index,
  input  logic [fpba_pkg::SIZE_BITS-1:0]        in_size_value,
  output logic                                  out_strobe,
  output logic                                  out_granted,
  output logic [fpba_pkg::IDX_W-1:0]            out_chosen_block,
  output logic [fpba_pkg::SIZE_BITS-1:0]        out_space_left,
  input  logic                                  cfg_we,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fpba_pkg::CFG_W-1:0]            cfg_wdata
);

  fpba_pkg::fpba_cmd_t cmd;
  fpba_pkg::fpba_sts_t sts;

  fpba_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_operation(in_operation),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  fpba_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_load_index   (in_load_index),
    .in_size_value   (in_size_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_strobe      (out_strobe),
    .out_granted     (out_granted),
    .out_chosen_block(out_chosen_block),
    .out_space_left  (out_space_left)
  );

endmodule

[rtl/fpba_chk.sv]
module fpba_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  in_operation,
  input logic                                  out_strobe,
  input logic                                  out_granted,
  input logic [fpba_pkg::IDX_W-1:0]            out_chosen_block,
  input logic [fpba_pkg::SIZE_BITS-1:0]        out_space_left
);

  // an allocate word occupies the block
  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation == fpba_pkg::OP_ALLOC |=> busy)
    else $error("allocate accepted without going busy");

  // a load word completes in its own cycle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation == fpba_pkg::OP_LOAD |=> !busy)
    else $error("load word left the block busy");

  // one result per allocate, delivered once the block is free again
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy ##1 !out_strobe)
    else $error("result strobe repeated or seen while busy");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_granted |-> out_chosen_block == '0 && out_space_left == '0)
    else $error("refused request carries nonzero fields");

endmodule

bind fit_policy_block_allocator_core fpba_chk u_chk (.*);

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import fpba_pkg::*;

  localparam logic [POLICY_W-1:0] POL_UNUSED = 2'd3;
  // longest scan plus write back and strobe, with margin
  localparam int SETTLE_CYCLES = MAX_BLOCKS + 8;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic                 granted;
    logic [IDX_W-1:0]     blk;
    logic [SIZE_BITS-1:0] left;
  } grant_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_operation = OP_LOAD;
  logic [IDX_W-1:0]     in_load_index = '0;
  logic [SIZE_BITS-1:0] in_size_value = '0;
  logic                 out_strobe;
  logic                 out_granted;
  logic [IDX_W-1:0]     out_chosen_block;
  logic [SIZE_BITS-1:0] out_space_left;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_POLICY;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // shadow of the allocator: free sizes and the two registers
  logic [SIZE_BITS-1:0] free_size_tbl [MAX_BLOCKS];
  logic [POLICY_W-1:0]  policy_sel = POL_FIRST;
  logic [COUNT_W-1:0]   block_limit = 5'd16;

  grant_t pending_grants [$];
  int     err_count = 0;
  int     cycle_count = 0;
  bit     idle_on = 1'b0;

  fit_policy_block_allocator_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_load_index    (in_load_index),
    .in_size_value    (in_size_value),
    .out_strobe       (out_strobe),
    .out_granted      (out_granted),
    .out_chosen_block (out_chosen_block),
    .out_space_left   (out_space_left),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fit_policy_block_allocator_core regression: fail");
      $finish;
    end
  end

  // applies one allocate to the shadow table and returns the word it must produce
  function automatic grant_t predict_grant(input logic [SIZE_BITS-1:0] req);
    grant_t g;
    int     scan_n;
    int     pick;
    int     j;
    bit     stop;
    g = '0;
    pick = -1;
    stop = 1'b0;
    scan_n = (block_limit > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_limit);
    for (j = 0; j < scan_n; j++) begin
      if (!stop && free_size_tbl[j] >= req) begin
        if (pick < 0) begin
          pick = j;
          // first fit and the unused code stop at the first hit
          stop = (policy_sel != POL_BEST) && (policy_sel != POL_WORST);
        end else if ((policy_sel == POL_BEST && free_size_tbl[j] < free_size_tbl[pick]) ||
                     (policy_sel == POL_WORST && free_size_tbl[j] > free_size_tbl[pick])) begin
          pick = j;
        end
      end
    end
    if (pick >= 0) begin
      free_size_tbl[pick] = free_size_tbl[pick] - req;
      g.granted = 1'b1;
      g.blk     = pick[IDX_W-1:0];
      g.left    = free_size_tbl[pick];
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t exp_g;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_grants.size() == 0) begin
        $error("result word with nothing pending: granted %0d block %0d left %0d",
               out_granted, out_chosen_block, out_space_left);
        err_count++;
      end else begin
        exp_g = pending_grants.pop_front();
        if (out_granted !== exp_g.granted) begin
          $error("granted: expected %0d, got %0d", exp_g.granted, out_granted);
          err_count++;
        end
        if (out_chosen_block !== exp_g.blk) begin
          $error("chosen_block: expected %0d, got %0d", exp_g.blk, out_chosen_block);
          err_count++;
        end
        if (out_space_left !== exp_g.left) begin
          $error("space_left: expected %0d, got %0d", exp_g.left, out_space_left);
          err_count++;
        end
      end
    end
  end

  // start is left high on return so the next word can follow without a gap
  task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [SIZE_BITS-1:0] size);
    start         <= 1'b1;
    in_operation  <= op;
    in_load_index <= idx;
    in_size_value <= size;
    do @(posedge clk); while (busy !== 1'b0);
    if (op == OP_LOAD) free_size_tbl[idx] = size;
    else pending_grants.push_back(predict_grant(size));
  endtask

  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // drain every pending word, let a trailing load settle, then write both registers
  task automatic settle_and_configure(input logic [CFG_W-1:0] pol_word,
                                      input logic [CFG_W-1:0] cnt_word);
    start <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_POLICY;
    cfg_wdata <= pol_word;
    @(posedge clk);
    policy_sel = pol_word[POLICY_W-1:0];
    cfg_index <= REG_COUNT;
    cfg_wdata <= cnt_word;
    @(posedge clk);
    block_limit = cnt_word;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SIZE_BITS-1:0] pick_load_size();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return SIZE_BITS'($urandom_range(0, 255));
      4:       return free_size_tbl[IDX_W'($urandom_range(0, MAX_BLOCKS - 1))]; // ties
      default: return SIZE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [SIZE_BITS-1:0] pick_request();
    logic [SIZE_BITS-1:0] near;
    near = free_size_tbl[IDX_W'($urandom_range(0, MAX_BLOCKS - 1))];
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return near;           // exact fit
      4:       return near + 1'b1;
      5:       return near - 1'b1;
      6, 7:    return SIZE_BITS'($urandom_range(0, 1023));
      default: return SIZE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd16;
      3:       return CFG_W'($urandom_range(17, 31));
      default: return CFG_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] policy_word(input logic [POLICY_W-1:0] pol);
    return {CFG_W'($urandom_range(0, 7)) << POLICY_W} | CFG_W'(pol);
  endfunction

  // every entry gets written before any allocate scans the table
  task automatic test_table_load();
    int i;
    settle_and_configure(CFG_W'(POL_FIRST), 5'd16);
    for (i = 0; i < MAX_BLOCKS; i++)
      send_word(OP_LOAD, i[IDX_W-1:0],
                (i == MAX_BLOCKS - 1) ? 16'hFFFF : SIZE_BITS'((i % 4) * 16'h1000));
  endtask

  task automatic test_first_fit_edges();
    send_word(OP_ALLOC, '0, 16'h0000);  // zero request on an empty block
    send_word(OP_ALLOC, '1, 16'hFFFF);
    send_word(OP_ALLOC, '0, 16'hFFFF);  // nothing left that large
    send_word(OP_ALLOC, '0, 16'h2800);
  endtask

  task automatic test_policy_rules();
    settle_and_configure(CFG_W'(POL_BEST), 5'd16);
    send_word(OP_ALLOC, '0, 16'h0800);
    send_word(OP_ALLOC, '0, 16'h1000);  // four-way tie, lowest index wins
    settle_and_configure(CFG_W'(POL_WORST), 5'd16);
    send_word(OP_ALLOC, '0, 16'h0001);
    settle_and_configure({3'b111, POL_UNUSED}, 5'd16);  // unused code acts as first fit
    send_word(OP_ALLOC, '0, 16'h1000);
  endtask

  task automatic test_count_edges();
    settle_and_configure(CFG_W'(POL_FIRST), 5'd0);
    send_word(OP_ALLOC, '0, 16'h0000);  // no blocks in use
    settle_and_configure(CFG_W'(POL_FIRST), 5'd1);
    send_word(OP_LOAD, 4'd9, 16'h7777); // stored although above the count
    send_word(OP_ALLOC, '0, 16'h0000);
    settle_and_configure(CFG_W'(POL_WORST), 5'd31); // saturates to all blocks
    send_word(OP_ALLOC, '0, 16'h7000);
  endtask

  task automatic run_mix(input int n_words);
    int k;
    for (k = 0; k < n_words; k++) begin
      if ($urandom_range(0, 99) < 35)
        send_word(OP_LOAD, IDX_W'($urandom_range(0, MAX_BLOCKS - 1)), pick_load_size());
      else
        send_word(OP_ALLOC, IDX_W'($urandom), pick_request());
      maybe_idle();
    end
  endtask

  task automatic test_random_phases();
    int ph;
    for (ph = 0; ph < 12; ph++) begin
      settle_and_configure(policy_word(POLICY_W'(ph % 4)), pick_count());
      idle_on = ($urandom_range(0, 3) != 0);
      run_mix(95);
    end
  endtask

  task automatic test_back_to_back();
    settle_and_configure(policy_word(POLICY_W'($urandom_range(0, 3))), 5'd16);
    idle_on = 1'b0;
    run_mix(60);
    settle_and_configure(policy_word(POL_BEST), 5'd1);
    run_mix(30);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_table_load();
    test_first_fit_edges();
    test_policy_rules();
    test_count_edges();
    test_random_phases();
    test_back_to_back();
    start <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("fit_policy_block_allocator_core regression: pass");
    end else begin
      $display("fit_policy_block_allocator_core regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/fpba_pkg.sv
rtl/fpba_ram.sv
rtl/fpba_ctrl.sv
rtl/fpba_dp.sv
rtl/fit_policy_block_allocator_core.sv
rtl/fpba_chk.sv
bench/testbench.sv
